### design/wsrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrc_pkg
// Shared types, widths and constants of the Wilson score rating comparator.
// ----------------------------------------------------------------------------
package wsrc_pkg;

  localparam int CW     = 16;            // vote count width
  localparam int FB     = 16;            // score fraction bits
  localparam int N_W    = CW + 1;        // width of n = u + d
  localparam int UD_W   = 2 * CW;        // width of u*d and u*u
  localparam int Y_W    = CW + 62;       // radicand width, Q60
  localparam int ROOT_W = Y_W / 2;       // square root width, Q30
  localparam int S_LO_W = ROOT_W / 2 + 1;
  localparam int S_HI_W = ROOT_W - S_LO_W;
  localparam int Z_W    = 31;
  localparam int PH_W   = Z_W + S_HI_W;
  localparam int PL_W   = Z_W + S_LO_W;
  localparam int ZS_W   = Z_W + ROOT_W + 1;
  localparam int T_W    = CW + 32;
  localparam int T_LO_W = T_W / 2;
  localparam int T_HI_W = T_W - T_LO_W;
  localparam int MH_W   = N_W + T_HI_W;
  localparam int ML_W   = N_W + T_LO_W;
  localparam int DEN2_W = N_W + T_W;
  localparam int NUM1_W = UD_W + 62;
  localparam int NUM2_W = UD_W + 31 + FB;
  localparam int SIDE_W = CW + N_W + UD_W + 1;

  // z = 1.959963971 in Q30, and its square in Q60.
  localparam logic [Z_W-1:0] Z_Q30 = 31'd2104495289;
  localparam logic [61:0]    Z_SQ  = 62'(Z_Q30) * 62'(Z_Q30);

  // Register stages through one lane.
  localparam int LANE_LAT = 1 + (Y_W + 1) + 1 + (ROOT_W + 1) + 4 + (FB + 1);

  typedef struct packed {
    logic [15:0] a_upvotes;
    logic [15:0] a_downvotes;
    logic [15:0] b_upvotes;
    logic [15:0] b_downvotes;
  } in_item_t;

  typedef struct packed {
    logic [15:0] score_a;
    logic [15:0] score_b;
    logic        a_less;
    logic        a_greater;
    logic        counts_equal;
  } out_item_t;

  typedef struct packed {
    logic [CW-1:0] up;
    logic [CW-1:0] down;
  } tally_t;

endpackage

### design/wilson_score_rating_compare_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilson_score_rating_compare_top
// Two Wilson lower-bound lanes, a compare stage and an output queue.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while in_ready is high and
// returns one result per transaction, in order. The pipeline depth is set by
// the two bit-per-stage division pipelines (79 and 17 stages) and the
// bit-per-stage square-root pipeline (40 stages) inside each lane. A two-entry
// output queue lets a new transaction enter while a result waits; the whole
// pipeline holds only when that queue is full and not being drained.
module wilson_score_rating_compare_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wsrc_pkg::out_item_t out_data
);

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  logic                en;
  logic [1:0]          cnt;
  logic                push;
  logic                pop;
  wsrc_pkg::out_item_t head;
  wsrc_pkg::out_item_t tail;

  assign en       = (cnt != QUEUE_DEPTH) || out_ready;
  assign in_ready = en;

  // Valid and equality flags ride beside the lanes.
  logic [wsrc_pkg::LANE_LAT-1:0] vld;
  logic [wsrc_pkg::LANE_LAT-1:0] eq_line;
  logic                          eq_in;

  assign eq_in = (in_data.a_upvotes == in_data.b_upvotes)
              && (in_data.a_downvotes == in_data.b_downvotes);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[wsrc_pkg::LANE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eq_line <= {eq_line[wsrc_pkg::LANE_LAT-2:0], eq_in};
    end
  end

  logic [wsrc_pkg::FB-1:0] score_a;
  logic [wsrc_pkg::FB-1:0] score_b;

  wsrc_lane u_lane_a (
    .clk  (clk),
    .en   (en),
    .tally('{up: in_data.a_upvotes, down: in_data.a_downvotes}),
    .score(score_a)
  );

  wsrc_lane u_lane_b (
    .clk  (clk),
    .en   (en),
    .tally('{up: in_data.b_upvotes, down: in_data.b_downvotes}),
    .score(score_b)
  );

  // Compare stage.
  logic                m_valid;
  wsrc_pkg::out_item_t m_item;
  logic                lane_eq;

  assign lane_eq = eq_line[wsrc_pkg::LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= vld[wsrc_pkg::LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item.score_a      <= score_a;
      m_item.score_b      <= score_b;
      m_item.a_less       <= !lane_eq && (score_a < score_b);
      m_item.a_greater    <= !lane_eq && (score_a > score_b);
      m_item.counts_equal <= lane_eq;
    end
  end

  // Two-entry output queue.
  assign push      = en && m_valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = cnt != 2'd0;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt == 2'd0) begin
        head <= m_item;
      end else begin
        tail <= m_item;
      end
    end else if (pop && !push) begin
      head <= tail;
    end else if (push && pop) begin
      if (cnt == 2'd1) begin
        head <= m_item;
      end else begin
        head <= tail;
        tail <= m_item;
      end
    end
  end

  // A push into a full queue must coincide with a pop.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    (push && cnt == QUEUE_DEPTH) |-> pop)
    else $error("output queue overflow");

  // Equal tallies never report an ordering.
  a_equal_unordered : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.counts_equal) |-> (!out_data.a_less && !out_data.a_greater))
    else $error("equal tallies reported as ordered");

  // Less and greater are exclusive.
  a_order_exclusive : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.a_less && out_data.a_greater))
    else $error("less and greater both set");

  // Reset empties the queue and the compare stage.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (cnt == 2'd0 && !m_valid))
    else $error("state not cleared by reset");

endmodule

### design/wsrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrc_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits. Side data travels alongside each transaction.
// ----------------------------------------------------------------------------
module wsrc_div #(
  parameter int NUM_W  = 94,
  parameter int DEN_W  = 17,
  parameter int QUO_W  = 78,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_r  [0:QUO_W-1];
  logic [QUO_W-1:0]  low_r  [0:QUO_W-1];
  logic [DEN_W-1:0]  den_r  [0:QUO_W-1];
  logic [QUO_W-1:0]  quo_r  [0:QUO_W];
  logic [SIDE_W-1:0] side_r [0:QUO_W];

  // Since the quotient fits, the bits above the low part are below den.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DEN_W'(num >> QUO_W);
      low_r[0]  <= num[QUO_W-1:0];
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      side_r[0] <= side;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_r[k], low_r[k][QUO_W-1]};
    assign diff  = trial - {1'b0, den_r[k]};
    assign take  = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1]  <= (quo_r[k] << 1) | QUO_W'(take);
        side_r[k+1] <= side_r[k];
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          low_r[k+1] <= low_r[k] << 1;
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign quo      = quo_r[QUO_W];
  assign side_out = side_r[QUO_W];

endmodule

### design/wsrc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrc_isqrt
// Pipelined integer square root, two radicand bits and one root bit per stage.
// ----------------------------------------------------------------------------
module wsrc_isqrt #(
  parameter int IN_W   = 78,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     y,
  input  logic [SIDE_W-1:0]   side,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [0:ROOT_W-1];
  logic [IN_W-1:0]   low_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  logic [SIDE_W-1:0] side_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      low_r[0]  <= y;
      root_r[0] <= '0;
      side_r[0] <= side;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             take;

    // The remainder never exceeds twice the root, so the dropped bits are zero.
    assign cur   = {rem_r[k][REM_W-3:0], low_r[k][IN_W-1 -: 2]};
    assign trial = REM_W'({root_r[k], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= (root_r[k] << 1) | ROOT_W'(take);
        side_r[k+1] <= side_r[k];
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? cur - trial : cur;
          low_r[k+1] <= low_r[k] << 2;
        end
      end
    end
  end

  assign root     = root_r[ROOT_W];
  assign side_out = side_r[ROOT_W];

endmodule

### design/wsrc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrc_lane
// One Wilson lower-bound lane: products, first division, square root, the
// denominator terms and the final division, all in a fixed-latency pipeline.
// ----------------------------------------------------------------------------
module wsrc_lane (
  input  logic                   clk,
  input  logic                   en,
  input  wsrc_pkg::tally_t       tally,
  output logic [wsrc_pkg::FB-1:0] score
);

  // Input products.
  logic [wsrc_pkg::CW-1:0]   u0;
  logic [wsrc_pkg::N_W-1:0]  n0;
  logic [wsrc_pkg::UD_W-1:0] ud0;
  logic [wsrc_pkg::UD_W-1:0] uu0;

  always_ff @(posedge clk) begin
    if (en) begin
      u0  <= tally.up;
      n0  <= wsrc_pkg::N_W'(tally.up) + wsrc_pkg::N_W'(tally.down);
      ud0 <= wsrc_pkg::UD_W'(tally.up) * wsrc_pkg::UD_W'(tally.down);
      uu0 <= wsrc_pkg::UD_W'(tally.up) * wsrc_pkg::UD_W'(tally.up);
    end
  end

  // floor(u*d * 2^62 / n)
  logic [wsrc_pkg::Y_W-1:0]    q1;
  logic [wsrc_pkg::SIDE_W-1:0] side1;

  wsrc_div #(
    .NUM_W (wsrc_pkg::NUM1_W),
    .DEN_W (wsrc_pkg::N_W),
    .QUO_W (wsrc_pkg::Y_W),
    .SIDE_W(wsrc_pkg::SIDE_W)
  ) u_div_y (
    .clk     (clk),
    .en      (en),
    .num     (wsrc_pkg::NUM1_W'(ud0) << 62),
    .den     (n0),
    .side    ({u0, n0, uu0, n0 == '0}),
    .quo     (q1),
    .side_out(side1)
  );

  logic [wsrc_pkg::Y_W-1:0]    y;
  logic [wsrc_pkg::SIDE_W-1:0] y_side;

  always_ff @(posedge clk) begin
    if (en) begin
      y      <= q1 + wsrc_pkg::Y_W'(wsrc_pkg::Z_SQ);
      y_side <= side1;
    end
  end

  logic [wsrc_pkg::ROOT_W-1:0] s;
  logic [wsrc_pkg::SIDE_W-1:0] side2;

  wsrc_isqrt #(
    .IN_W  (wsrc_pkg::Y_W),
    .SIDE_W(wsrc_pkg::SIDE_W)
  ) u_isqrt (
    .clk     (clk),
    .en      (en),
    .y       (y),
    .side    (y_side),
    .root    (s),
    .side_out(side2)
  );

  logic [wsrc_pkg::CW-1:0]   s2_u;
  logic [wsrc_pkg::N_W-1:0]  s2_n;
  logic [wsrc_pkg::UD_W-1:0] s2_uu;
  logic                      s2_zero;

  assign {s2_u, s2_n, s2_uu, s2_zero} = side2;

  // z * S as two partial products.
  logic [wsrc_pkg::PH_W-1:0] p_hi;
  logic [wsrc_pkg::PL_W-1:0] p_lo;
  logic [wsrc_pkg::CW-1:0]   p_u;
  logic [wsrc_pkg::N_W-1:0]  p_n;
  logic [wsrc_pkg::UD_W-1:0] p_uu;
  logic                      p_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi   <= wsrc_pkg::PH_W'(wsrc_pkg::Z_Q30)
                * wsrc_pkg::PH_W'(s[wsrc_pkg::ROOT_W-1:wsrc_pkg::S_LO_W]);
      p_lo   <= wsrc_pkg::PL_W'(wsrc_pkg::Z_Q30)
                * wsrc_pkg::PL_W'(s[wsrc_pkg::S_LO_W-1:0]);
      p_u    <= s2_u;
      p_n    <= s2_n;
      p_uu   <= s2_uu;
      p_zero <= s2_zero;
    end
  end

  // T = u*2^31 + z^2/2^30 + z*S/2^30, all in Q30.
  logic [wsrc_pkg::ZS_W-1:0] zs_sum;
  logic [wsrc_pkg::T_W-1:0]  t;
  logic [wsrc_pkg::N_W-1:0]  t_n;
  logic [wsrc_pkg::UD_W-1:0] t_uu;
  logic                      t_zero;

  assign zs_sum = (wsrc_pkg::ZS_W'(p_hi) << wsrc_pkg::S_LO_W) + wsrc_pkg::ZS_W'(p_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      t      <= (wsrc_pkg::T_W'(p_u) << 31) + wsrc_pkg::T_W'(wsrc_pkg::Z_SQ >> 30)
                + wsrc_pkg::T_W'(zs_sum >> 30);
      t_n    <= p_n;
      t_uu   <= p_uu;
      t_zero <= p_zero;
    end
  end

  // n * T as two partial products.
  logic [wsrc_pkg::MH_W-1:0] m_hi;
  logic [wsrc_pkg::ML_W-1:0] m_lo;
  logic [wsrc_pkg::UD_W-1:0] m_uu;
  logic                      m_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      m_hi   <= wsrc_pkg::MH_W'(t_n) * wsrc_pkg::MH_W'(t[wsrc_pkg::T_W-1:wsrc_pkg::T_LO_W]);
      m_lo   <= wsrc_pkg::ML_W'(t_n) * wsrc_pkg::ML_W'(t[wsrc_pkg::T_LO_W-1:0]);
      m_uu   <= t_uu;
      m_zero <= t_zero;
    end
  end

  logic [wsrc_pkg::DEN2_W-1:0] den2;
  logic [wsrc_pkg::NUM2_W-1:0] num2;
  logic                        d_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      den2   <= (wsrc_pkg::DEN2_W'(m_hi) << wsrc_pkg::T_LO_W) + wsrc_pkg::DEN2_W'(m_lo);
      num2   <= wsrc_pkg::NUM2_W'(m_uu) << (31 + wsrc_pkg::FB);
      d_zero <= m_zero;
    end
  end

  // Since n*T exceeds u^2 * 2^31, the quotient always fits in FB bits.
  logic [wsrc_pkg::FB-1:0] q2;
  logic                    q2_zero;

  wsrc_div #(
    .NUM_W (wsrc_pkg::NUM2_W),
    .DEN_W (wsrc_pkg::DEN2_W),
    .QUO_W (wsrc_pkg::FB),
    .SIDE_W(1)
  ) u_div_score (
    .clk     (clk),
    .en      (en),
    .num     (num2),
    .den     (den2),
    .side    (d_zero),
    .quo     (q2),
    .side_out(q2_zero)
  );

  assign score = q2_zero ? '0 : q2;

endmodule
